FILE: rtl/lrukv_pkg.sv
// lrukv_pkg: shared types and constants for the lru key/value cache
// request and response transaction structs, action codes, store sizing
// no dependencies
package lrukv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_PUT = 1'b1
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic signed [KEY_W-1:0]   key;
		logic signed [VAL_W-1:0]   data_in;
	} req_t;

	typedef struct packed {
		logic                      found;
		logic signed [VAL_W-1:0]   data_out;
	} rsp_t;

endpackage

FILE: rtl/lrukv_store.sv
// lrukv_store: entry storage, parallel key match and lru rank update
// one transaction is looked up combinationally and its update registered when en is high
// depends on lrukv_pkg
module lrukv_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  lrukv_pkg::req_t              item,
	input  logic [lrukv_pkg::CAP_W-1:0]  capacity,
	output lrukv_pkg::rsp_t              result
);
	import lrukv_pkg::*;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [KEY_W-1:0]   key_q  [MAX_ENTRIES];
	logic [VAL_W-1:0]   val_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]   rank_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;

	logic [MAX_ENTRIES-1:0] hit_vec;
	logic               hit;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   hit_rank;
	logic [VAL_W-1:0]   hit_val;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   old_idx;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CMP_W-1:0]   cap_w;
	logic [CMP_W-1:0]   cnt_w;
	logic               room;
	logic               is_put;
	logic               upd;
	logic               wr_key;
	logic               wr_val;
	logic               ins_free;
	logic [IDX_W-1:0]   tgt;
	logic [IDX_W:0]     thr;

	// parallel match and one-hot read of the hit entry
	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == item.key);
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			hit_rank = hit_rank | (rank_q[i] & {IDX_W{hit_vec[i]}});
			hit_val  = hit_val  | (val_q[i]  & {VAL_W{hit_vec[i]}});
		end
		hit = |hit_vec;
	end

	// lowest free slot, and the oldest valid entry (rank count-1)
	always_comb begin
		free_idx = '0;
		old_idx  = '0;
		cnt_m1   = count_q - CNT_W'(1);
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (valid_q[i] && (rank_q[i] == cnt_m1[IDX_W-1:0])) begin
				old_idx = IDX_W'(i);
			end
		end
	end

	// effective capacity: zero acts as one, saturates at the store size
	always_comb begin
		cap_w = CMP_W'(capacity);
		if (cap_w == '0) begin
			cap_w = CMP_W'(1);
		end else if (cap_w > CMP_W'(MAX_ENTRIES)) begin
			cap_w = CMP_W'(MAX_ENTRIES);
		end
		cnt_w = CMP_W'(count_q);
		room  = cnt_w < cap_w;
	end

	always_comb begin
		is_put   = (item.action == ACT_PUT);
		upd      = en && (is_put || hit);
		wr_val   = en && is_put;
		wr_key   = en && is_put && !hit;
		ins_free = en && is_put && !hit && room;
		if (hit) begin
			tgt = hit_idx;
			thr = {1'b0, hit_rank};
		end else if (room) begin
			tgt = free_idx;
			thr = {1'b1, {IDX_W{1'b0}}};	// every valid entry ages
		end else begin
			tgt = old_idx;
			thr = {1'b0, cnt_m1[IDX_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (upd) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (IDX_W'(i) == tgt) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && ({1'b0, rank_q[i]} < thr)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end
			if (ins_free) begin
				valid_q[tgt] <= 1'b1;
				count_q      <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_q[tgt] <= item.key;
		end
		if (wr_val) begin
			val_q[tgt] <= item.data_in;
		end
	end

	always_comb begin
		result.found    = hit;
		result.data_out = hit ? hit_val : '1;
	end

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_q)) == count_q)
		else $error("entry count differs from number of valid entries");

	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one entry matches a key");

	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && is_put && !hit && !room |=> $stable(count_q))
		else $error("eviction changed the entry count");

	a_put_fills: assert property (@(posedge clk) disable iff (!arst_n)
		en && is_put |=> valid_q != '0)
		else $error("store empty after a put");

endmodule

FILE: rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level with request register, store and response register
// depends on lrukv_pkg and lrukv_store
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_t: action, key, data_in
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_t: found, data_out (gets only)
//  cfg     | in        | cfg_valid/cfg_ready  | capacity (5 bits)
//
// one transaction per cycle while req_stall is low; a get answer passes the request register
// and then the response register; the lookup and lru update run between the two registers,
// and the update is seen by the very next transaction
// a put never waits on rsp; a get waits in the request register while an answer is held and rsp stalls
// reset clears valid marks, ranks, count and sets capacity to 16; no clearing pass
module lru_key_value_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  lrukv_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output lrukv_pkg::rsp_t              rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lrukv_pkg::CAP_W-1:0]  cfg_data
);
	import lrukv_pkg::*;

	req_t             req_s1;
	logic             vld_s1;
	rsp_t             rsp_q;
	logic             rsp_vld_q;
	logic [CAP_W-1:0] capacity_q;
	rsp_t             res;
	logic             emits;
	logic             out_free;
	logic             adv;

	assign cfg_ready = 1'b1;
	assign emits     = vld_s1 && (req_s1.action == ACT_GET);
	assign out_free  = !rsp_vld_q || !rsp_stall;
	assign adv       = vld_s1 && (!emits || out_free);
	assign req_stall = vld_s1 && !adv;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv && emits) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv && emits) begin
			rsp_q <= res;
		end
	end

	lrukv_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.item     (req_s1),
		.capacity (capacity_q),
		.result   (res)
	);

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for lru_key_value_cache
// keeps a shadow copy of the lru store and checks every get answer in order
// depends on lrukv_pkg and the rtl top level only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrukv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// shadow of the store
	logic [KEY_W-1:0] sh_key [MAX_ENTRIES];
	logic [VAL_W-1:0] sh_val [MAX_ENTRIES];
	bit sh_vld [MAX_ENTRIES];
	int unsigned sh_rank [MAX_ENTRIES];
	int unsigned sh_count = 0;
	logic [CAP_W-1:0] sh_cap = CAP_RESET;

	rsp_t pending_lookups[$];

	int n_gets = 0;
	int n_hits = 0;
	int n_puts = 0;
	int n_evicts = 0;
	int n_cfg = 0;
	int errors = 0;
	int unsigned cycle_count = 0;
	int stall_left = 0;
	bit rsp_calm = 1'b0;
	bit req_calm = 1'b0;

	lru_key_value_cache uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			sh_vld[i] = 1'b0;
			sh_rank[i] = 0;
		end
	end

	// entries more recent than slot s age by one, s becomes most recent
	function automatic void make_recent(input int s);
		int unsigned r;
		r = sh_rank[s];
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (sh_vld[i] && i != s && sh_rank[i] < r)
				sh_rank[i]++;
		sh_rank[s] = 0;
	endfunction

	// apply one accepted transaction to the shadow store, queue the answer of a get
	function automatic void shadow_access(input req_t r);
		int s;
		int eff;
		int unsigned oldest;
		bit any;
		rsp_t e;
		s = -1;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (s < 0 && sh_vld[i] && sh_key[i] == r.key)
				s = i;
		if (r.action == ACT_GET) begin
			n_gets++;
			if (s >= 0) begin
				make_recent(s);
				e.found = 1'b1;
				e.data_out = sh_val[s];
				n_hits++;
			end else begin
				e.found = 1'b0;
				e.data_out = '1;
			end
			pending_lookups.push_back(e);
			return;
		end
		n_puts++;
		if (s >= 0) begin
			sh_val[s] = r.data_in;
			make_recent(s);
			return;
		end
		eff = (sh_cap == 0) ? 1 : ((sh_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(sh_cap));
		if (sh_count < eff) begin
			for (int i = MAX_ENTRIES - 1; i >= 0; i--)
				if (!sh_vld[i])
					s = i;
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (sh_vld[i])
					sh_rank[i]++;
			sh_vld[s] = 1'b1;
			sh_rank[s] = 0;
			sh_count++;
		end else begin
			// full, or capacity lowered below the count: replace least recent
			s = 0;
			any = 1'b0;
			oldest = 0;
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (sh_vld[i] && (!any || sh_rank[i] > oldest)) begin
					s = i;
					oldest = sh_rank[i];
					any = 1'b1;
				end
			make_recent(s);
			n_evicts++;
		end
		sh_key[s] = r.key;
		sh_val[s] = r.data_in;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input action_t a, input logic [31:0] k, input logic [31:0] v);
		req_t r;
		int gap;
		r.action = a;
		r.key = k;
		r.data_in = v;
		if ($urandom_range(0, 59) == 0)
			req_calm = !req_calm;
		if (req_calm)
			gap = 0;
		else if ($urandom_range(0, 99) < 55)
			gap = 0;
		else if ($urandom_range(0, 19) != 0)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(12, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			req <= {1'($urandom), $urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		shadow_access(r);
		@(negedge clk);
	endtask

	// let every get answer out and the last puts settle
	task automatic drain_pipeline();
		req_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		sh_cap = cap;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_item(ACT_GET, 32'd5, 32'd9);
		send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ACT_GET, 32'h8000_0000, 32'h0);
		send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
		// stored -1 must come back with found set
		send_item(ACT_GET, 32'h0000_0000, 32'h0);
		send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(ACT_PUT, 32'h8000_0000, 32'h1234_5678);
		send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(ACT_GET, 32'h5555_5555, 32'hAAAA_AAAA);
		// four entries held, capacity dropped to two: new keys replace the oldest
		set_capacity(5'd2);
		send_item(ACT_PUT, 32'd7, 32'd70);
		send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
		send_item(ACT_GET, 32'd7, 32'h0);
		send_item(ACT_PUT, 32'd8, 32'd80);
		send_item(ACT_GET, 32'h0000_0000, 32'h0);
		send_item(ACT_GET, 32'd8, 32'h0);
		send_item(ACT_PUT, 32'd8, 32'd81);
		send_item(ACT_GET, 32'd8, 32'h0);
	endtask

	// random gets and puts over a small key set so hits and evictions are frequent
	task automatic test_random_mix(input logic [CAP_W-1:0] cap, input int n, input int pool);
		logic [31:0] keys [32];
		logic [31:0] k;
		logic [31:0] last_k;
		action_t a;
		int r;
		set_capacity(cap);
		for (int i = 0; i < pool; i++)
			keys[i] = $urandom;
		keys[$urandom_range(0, pool - 1)] = pick_value();
		last_k = keys[0];
		repeat (n) begin
			a = ($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET;
			r = $urandom_range(0, 99);
			if (r < 20)
				k = last_k;
			else if (r < 90)
				k = keys[$urandom_range(0, pool - 1)];
			else
				k = $urandom;
			send_item(a, k, pick_value());
			last_k = k;
		end
	endtask

	task automatic test_capacity_bounds();
		test_random_mix(5'd1, 100, 3);
		test_random_mix(5'd0, 60, 3);
		test_random_mix(5'd31, 150, 24);
		test_random_mix(5'd17, 80, 20);
		test_random_mix(5'd5, 150, 8);
	endtask

	task automatic test_capacity_shrink();
		set_capacity(5'd16);
		repeat (20) send_item(ACT_PUT, $urandom, pick_value());
		test_random_mix(5'd3, 120, 10);
	endtask

	task automatic test_random_capacity();
		repeat (4) test_random_mix(5'($urandom_range(0, 31)), 40, $urandom_range(2, 24));
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_mix(5'd16, 400, 22);
		test_capacity_bounds();
		test_capacity_shrink();
		test_random_capacity();
		drain_pipeline();
		$display("covered %0d gets (%0d hits) and %0d puts (%0d evictions)", n_gets, n_hits,
			n_puts, n_evicts);
		$display("across %0d capacity writes, %0d mismatches", n_cfg, errors);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// receiver back-pressure: mostly short stalls, a few long, calm stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			rsp_calm = !rsp_calm;
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_calm || $urandom_range(0, 99) < 60) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end
	end

	// answer checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected answer found %0b data_out %h", $time, rsp.found,
					rsp.data_out);
				errors++;
			end else begin
				if (rsp.found !== pending_lookups[0].found) begin
					$display("%0t: found mismatch, expected %0b actual %0b", $time,
						pending_lookups[0].found, rsp.found);
					errors++;
				end
				if (rsp.data_out !== pending_lookups[0].data_out) begin
					$display("%0t: data_out mismatch, expected %h actual %h", $time,
						pending_lookups[0].data_out, rsp.data_out);
					errors++;
				end
				void'(pending_lookups.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_lookups.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

endmodule

FILE: filelist.f
rtl/lrukv_pkg.sv
rtl/lrukv_store.sv
rtl/lru_key_value_cache.sv
dv/tb_top.sv
